// ===== src/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
package sida_pkg;

  // One BCD digit
  localparam int DIGIT_W = 4;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Character encoding
  localparam int CHAR_W = 7;
  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_ZERO  = 7'd48;
  localparam char_t CH_MINUS = 7'd45;

  // Double-dabble correction threshold and offset
  localparam digit_t DABBLE_MIN = 4'd5;
  localparam digit_t DABBLE_ADD = 4'd3;

  // Binary bits shifted into the BCD register per pipeline stage
  localparam int BITS_PER_STAGE = 4;

endpackage

// ===== src/sida_stage.sv =====
// One double-dabble pipeline stage: shifts a few binary bits into the BCD digits.
module sida_stage
  import sida_pkg::*;
#(
  parameter int DIGITS = 10,
  parameter int BIN_W  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic                      sign_in,
  input  logic [BIN_W-1:0]          bin_in,
  input  logic [DIGITS*DIGIT_W-1:0] bcd_in,
  output logic                      valid,
  output logic                      sign,
  output logic [BIN_W-1:0]          bin,
  output logic [DIGITS*DIGIT_W-1:0] bcd
);

  localparam int BCD_W = DIGITS * DIGIT_W;

  logic [BIN_W-1:0] bin_next;
  logic [BCD_W-1:0] bcd_next;

  // Add-3 correction on every digit, then shift one bit in; repeated per bit
  always_comb begin
    bin_next = bin_in;
    bcd_next = bcd_in;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int j = 0; j < DIGITS; j++) begin
        if (bcd_next[j*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
          bcd_next[j*DIGIT_W +: DIGIT_W] = bcd_next[j*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
        end
      end
      // top bit of the digit field is always zero here: the value fits
      {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      sign <= sign_in;
      bin  <= bin_next;
      bcd  <= bcd_next;
    end
  end

endmodule

// ===== src/sida_ser.sv =====
// Character serializer: walks one word's BCD digits out through an output register.
module sida_ser
  import sida_pkg::*;
#(
  parameter int DIGITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ld_valid,
  output logic                      ld_ready,
  input  logic                      ld_sign,
  input  logic [DIGITS*DIGIT_W-1:0] ld_bcd,
  output logic                      char_valid,
  input  logic                      char_ready,
  output char_t                     ascii_char,
  output logic                      last_char
);

  localparam int IDX_W = $clog2(DIGITS);

  logic                      busy;
  logic                      neg_pend;
  logic [IDX_W-1:0]          pos;
  logic [DIGITS*DIGIT_W-1:0] dig;

  logic             out_free;
  logic             emit;
  logic             finish;
  logic             load;
  logic [IDX_W-1:0] msd;
  digit_t           cur;

  assign out_free = !char_valid || char_ready;
  assign emit     = busy && out_free;
  assign finish   = emit && !neg_pend && (pos == '0);
  assign ld_ready = !busy || finish;
  assign load     = ld_valid && ld_ready;
  assign cur      = dig[pos*DIGIT_W +: DIGIT_W];

  // Most significant nonzero digit; zero gives index 0
  always_comb begin
    msd = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (ld_bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  // Control: busy flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (out_free) begin
        char_valid <= busy;
      end
      if (finish) begin
        busy <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end
    end
  end

  // Payload: minus sign first, then digits from the top down
  always_ff @(posedge clk) begin
    if (emit) begin
      if (neg_pend) begin
        ascii_char <= CH_MINUS;
        last_char  <= 1'b0;
        neg_pend   <= 1'b0;
      end else begin
        ascii_char <= CH_ZERO + char_t'(cur);
        last_char  <= (pos == '0);
        if (pos != '0) begin
          pos <= pos - IDX_W'(1);
        end
      end
    end
    if (load) begin
      neg_pend <= ld_sign;
      pos      <= msd;
      dig      <= ld_bcd;
    end
  end

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Top level: signed binary to decimal ASCII text, pipelined conversion plus serializer.
//
//   channel  handshake                 payload               one word is
//   item     item_valid / item_ready   value                 a signed integer
//   char     char_valid / char_ready   ascii_char, last_char one text character
//
// A word passes an input register and ceil(VALUE_BITS/4) double-dabble stages
// (8 at 32 bits), then the serializer's busy flag and its output register.
// The output sends 1 to 11 characters per word at 32 bits (sign plus digits), one per
// cycle while char_ready is high, so the char port sets the sustained rate: a word
// per run length. The pipeline takes a new word every cycle while it has room; a
// stall on char backs up stage by stage without loss. Reset clears valid and busy bits.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         char_valid,
  input  logic                         char_ready,
  output logic [CHAR_W-1:0]            ascii_char,
  output logic                         last_char
);

  // Digits of the largest magnitude, 2^(VALUE_BITS-1): floor(log10) + 1
  localparam int NUM_DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int NSTG       = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PAD_W      = NSTG * BITS_PER_STAGE;

  logic             v_s    [0:NSTG];
  logic             sign_s [0:NSTG];
  logic [PAD_W-1:0] bin_s  [0:NSTG];
  logic [BCD_W-1:0] bcd_s  [0:NSTG];
  logic             rdy    [0:NSTG];

  logic                  ser_ready;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;

  // Magnitude as unsigned; the most negative value maps to 2^(VALUE_BITS-1)
  assign in_neg = value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

  // Each stage loads when empty or when its word moves on
  assign rdy[NSTG] = !v_s[NSTG] || ser_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v_s[k] || rdy[k+1];
  end
  assign item_ready = rdy[0];

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_s[0] <= item_valid;
    end
  end

  // Magnitude padded with leading zeros to a whole number of stages
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sign_s[0] <= in_neg;
      bin_s[0]  <= PAD_W'(in_mag);
      bcd_s[0]  <= '0;
    end
  end

  // Double-dabble stages
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    sida_stage #(
      .DIGITS (NUM_DIGITS),
      .BIN_W  (PAD_W)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (rdy[k]),
      .valid_in (v_s[k-1]),
      .sign_in  (sign_s[k-1]),
      .bin_in   (bin_s[k-1]),
      .bcd_in   (bcd_s[k-1]),
      .valid    (v_s[k]),
      .sign     (sign_s[k]),
      .bin      (bin_s[k]),
      .bcd      (bcd_s[k])
    );
  end

  // Character serializer and output register
  sida_ser #(
    .DIGITS (NUM_DIGITS)
  ) u_ser (
    .clk        (clk),
    .rst        (rst),
    .ld_valid   (v_s[NSTG]),
    .ld_ready   (ser_ready),
    .ld_sign    (sign_s[NSTG]),
    .ld_bcd     (bcd_s[NSTG]),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule
